// File: rtl/core/ybh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ybh_pkg: shared types and constants
// Beat structures, mode and register codes, and the fixed-point color
// factors for the YUV422 to BGR converter with histogram and scope.
// ----------------------------------------------------------------------------
package ybh_pkg;

    // Default sizes of the histogram store.
    localparam int HIST_BINS_DEF  = 256;
    localparam int COUNT_BITS_DEF = 21;

    // The vectorscope map is 128 rows of 128 cells.
    localparam int SCOPE_CELLS = 16384;
    localparam int SCOPE_ROWS  = 128;
    localparam int SCOPE_COLS  = 128;
    localparam int SCOPE_RW    = $clog2(SCOPE_ROWS);
    localparam int SCOPE_CW    = $clog2(SCOPE_COLS);

    // Item modes.
    localparam logic [1:0] MODE_PIXEL      = 2'd0;
    localparam logic [1:0] MODE_CLEAR      = 2'd1;
    localparam logic [1:0] MODE_READ_BIN   = 2'd2;
    localparam logic [1:0] MODE_READ_SCOPE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_HIST_EN  = 2'd0;
    localparam logic [1:0] REG_SCOPE_EN = 2'd1;
    localparam logic [1:0] REG_SHIFT    = 2'd2;

    // Q16 BT.709 factors and the chroma offset.
    localparam int PROD_W = 27;
    localparam logic signed [PROD_W-1:0] K_CB_B = 27'sd121609;
    localparam logic signed [PROD_W-1:0] K_CB_G = 27'sd12275;
    localparam logic signed [PROD_W-1:0] K_CR_G = 27'sd30677;
    localparam logic signed [PROD_W-1:0] K_CR_R = 27'sd103206;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam logic signed [PROD_W-1:0] CHAN_SAT = 27'sd16711680;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  luma_first;
        logic [7:0]  chroma_blue;
        logic [7:0]  luma_second;
        logic [7:0]  chroma_red;
        logic [13:0] read_index;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  blue_first;
        logic [7:0]  green_first;
        logic [7:0]  red_first;
        logic [7:0]  blue_second;
        logic [7:0]  green_second;
        logic [7:0]  red_second;
        logic [15:0] bin_level;
        logic        scope_hit;
    } out_beat_t;

    // Three channels of one pixel.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } bgr_t;

endpackage
`default_nettype wire

// File: rtl/core/ybh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ybh_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ybh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first in program order; a read sees data from earlier edges.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/ybh_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ybh_lane: one pixel lane of the color converter
// Adds the scaled luma to the shared chroma terms and clamps each channel.
// ----------------------------------------------------------------------------
module ybh_lane
    import ybh_pkg::*;
(
    input  wire logic [7:0]               luma,
    input  wire logic signed [PROD_W-1:0] term_b,
    input  wire logic signed [PROD_W-1:0] term_g,
    input  wire logic signed [PROD_W-1:0] term_r,
    output bgr_t                          pixel
);

    logic signed [PROD_W-1:0] base;
    logic signed [PROD_W-1:0] sum_b;
    logic signed [PROD_W-1:0] sum_g;
    logic signed [PROD_W-1:0] sum_r;

    function automatic logic [7:0] clamp_chan(input logic signed [PROD_W-1:0] t);
        logic [7:0] res;
        if (t <= 0) begin
            res = 8'd0;
        end else if (t >= CHAN_SAT) begin
            res = 8'hFF;
        end else begin
            res = t[23:16];
        end
        return res;
    endfunction

    // Luma in Q16 plus each channel's chroma term.
    assign base  = signed'(PROD_W'({luma, 16'h0000}));
    assign sum_b = base + term_b;
    assign sum_g = base + term_g;
    assign sum_r = base + term_r;

    assign pixel.blue  = clamp_chan(sum_b);
    assign pixel.green = clamp_chan(sum_g);
    assign pixel.red   = clamp_chan(sum_r);

endmodule
`default_nettype wire

// File: rtl/core/ybh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ybh_div: restoring divider for bin normalization
// Produces one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module ybh_div #(
    parameter int COUNT_BITS = 21
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [COUNT_BITS+7:0]   num,
    input  wire logic [COUNT_BITS-1:0]   den,
    output logic      [COUNT_BITS+7:0]   quo,
    output logic                         done
);

    localparam int NUM_W = COUNT_BITS + 8;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]    num_reg, num_next;
    logic [COUNT_BITS:0] rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [COUNT_BITS:0] trial;
    logic                fits;

    // Shift in the next numerator bit and try a subtraction.
    assign trial = {rem_reg[COUNT_BITS-1:0], num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = fits ? trial - {1'b0, den} : trial;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// File: rtl/core/yuv422_to_bgr_with_histogram_scope.sv
`default_nettype none
// One item at a time: s_ready is low from acceptance until the result beat is registered.
// A pixel beat makes two read-modify-write passes (ST_RD, ST_WR), one per luma, through
// the single write port of the histogram memory; a bin read may add a divide in ST_DIV,
// and every item ends in ST_DONE, which waits until the output register is free.
// Reset: synchronous, active low; afterwards a clearing pass zeroes both memories while
// s_ready stays low (configuration writes go on).
// ----------------------------------------------------------------------------
// yuv422_to_bgr_with_histogram_scope: YUV422 to BGR with luma histogram
// Two pixel lanes convert a macropixel; a sequencer updates the histogram,
// the vectorscope map, and serves clear and read requests.
// ----------------------------------------------------------------------------
module yuv422_to_bgr_with_histogram_scope
    import ybh_pkg::*;
#(
    parameter int HIST_BINS  = HIST_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int HB_W      = $clog2(HIST_BINS);
    localparam int NUM_W     = COUNT_BITS + 8;
    localparam int CLR_DEPTH = (HIST_BINS > SCOPE_ROWS) ? HIST_BINS : SCOPE_ROWS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [8:0] LAST_IDX = 9'(HIST_BINS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_RD    = 6'b000100,
        ST_WR    = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    in_beat_t                 item_reg, item_next;
    logic                     phase_reg, phase_next;
    logic                     init_reg, init_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;
    logic [COUNT_BITS-1:0]    peak_reg, peak_next;
    logic                     hist_en_reg, scope_en_reg;
    logic [2:0]               shift_reg;
    logic signed [PROD_W-1:0] prod_b_reg, prod_g_reg, prod_r_reg;
    logic signed [PROD_W-1:0] prod_b_next, prod_g_next, prod_r_next;
    logic [15:0]              level_reg, level_next;
    logic                     hit_reg, hit_next;
    out_beat_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     hist_we, scope_we;
    logic [HB_W-1:0]          hist_waddr, hist_raddr;
    logic [COUNT_BITS-1:0]    hist_wdata, hist_rdata;
    logic [SCOPE_RW-1:0]      scope_waddr, scope_raddr;
    logic [SCOPE_COLS-1:0]    scope_wdata, scope_rdata;

    logic                     div_start, div_done;
    logic [NUM_W-1:0]         div_quo;

    logic                     accept;
    logic [7:0]               luma_shifted_0, luma_shifted_1, last_raw;
    logic [HB_W-1:0]          bin_0, bin_1, cur_bin;
    logic [8:0]               last_bin;
    logic [COUNT_BITS-1:0]    count_inc;
    logic signed [PROD_W-1:0] u_ext, v_ext;
    bgr_t                     pix_first, pix_second;

    // Configuration writes are taken at any time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_en_reg  <= 1'b1;
            scope_en_reg <= 1'b1;
            shift_reg    <= 3'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HIST_EN:  hist_en_reg  <= cfg_data[0];
                REG_SCOPE_EN: scope_en_reg <= cfg_data[0];
                REG_SHIFT:    shift_reg    <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // Histogram bins of both lumas, saturated to the last bin of the store.
    assign luma_shifted_0 = item_reg.luma_first >> shift_reg;
    assign luma_shifted_1 = item_reg.luma_second >> shift_reg;
    assign bin_0 = ({1'b0, luma_shifted_0} > LAST_IDX) ? LAST_IDX[HB_W-1:0]
                                                       : luma_shifted_0[HB_W-1:0];
    assign bin_1 = ({1'b0, luma_shifted_1} > LAST_IDX) ? LAST_IDX[HB_W-1:0]
                                                       : luma_shifted_1[HB_W-1:0];
    assign cur_bin  = phase_reg ? bin_1 : bin_0;
    assign last_raw = 8'hFF >> shift_reg;
    assign last_bin = ({1'b0, last_raw} > LAST_IDX) ? LAST_IDX : {1'b0, last_raw};
    assign count_inc = (hist_rdata != {COUNT_BITS{1'b1}}) ? hist_rdata + 1'b1
                                                         : hist_rdata;

    // Centered chroma, sign-extended for the shared multipliers.
    assign u_ext = signed'(PROD_W'(signed'({1'b0, item_reg.chroma_blue} - CHROMA_OFFSET)));
    assign v_ext = signed'(PROD_W'(signed'({1'b0, item_reg.chroma_red} - CHROMA_OFFSET)));
    assign prod_b_next = K_CB_B * u_ext;
    assign prod_g_next = -(K_CB_G * u_ext) - (K_CR_G * v_ext);
    assign prod_r_next = K_CR_R * v_ext;

    // Memory read addresses follow the item mode and pass.
    assign hist_raddr  = (item_reg.mode == MODE_READ_BIN) ? item_reg.read_index[HB_W-1:0]
                                                          : cur_bin;
    assign scope_raddr = (item_reg.mode == MODE_READ_SCOPE)
                         ? item_reg.read_index[SCOPE_RW+SCOPE_CW-1:SCOPE_CW]
                         : item_reg.chroma_red[7:1];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer for the histogram, scope and output handoff.
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        phase_next     = phase_reg;
        init_next      = init_reg;
        clr_next       = clr_reg;
        peak_next      = peak_reg;
        level_next     = level_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hist_we        = 1'b0;
        hist_waddr     = cur_bin;
        hist_wdata     = count_inc;
        scope_we       = 1'b0;
        scope_waddr    = item_reg.chroma_red[7:1];
        scope_wdata    = scope_rdata | (SCOPE_COLS'(1) << item_reg.chroma_blue[7:1]);
        div_start      = 1'b0;

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_data;
                    phase_next = 1'b0;
                    level_next = '0;
                    hit_next   = 1'b0;
                    clr_next   = '0;
                    state_next = (s_data.mode == MODE_CLEAR) ? ST_CLEAR : ST_RD;
                end
            end
            ST_CLEAR: begin
                hist_we     = ({1'b0, clr_reg} < (CLR_W+1)'(HIST_BINS));
                hist_waddr  = clr_reg[HB_W-1:0];
                hist_wdata  = '0;
                scope_we    = ({1'b0, clr_reg} < (CLR_W+1)'(SCOPE_ROWS));
                scope_waddr = clr_reg[SCOPE_RW-1:0];
                scope_wdata = '0;
                peak_next   = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                case (item_reg.mode)
                    MODE_PIXEL: begin
                        hist_we  = hist_en_reg;
                        scope_we = scope_en_reg && !phase_reg;
                        if (hist_en_reg && ({1'b0, cur_bin} < last_bin)
                                && (count_inc > peak_reg)) begin
                            peak_next = count_inc;
                        end
                        phase_next = 1'b1;
                        state_next = phase_reg ? ST_DONE : ST_RD;
                    end
                    MODE_READ_BIN: begin
                        if ((item_reg.read_index < 14'(HIST_BINS)) && (peak_reg != '0)) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    MODE_READ_SCOPE: begin
                        hit_next   = scope_rdata[item_reg.read_index[SCOPE_CW-1:0]];
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    level_next = (|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Merge the lanes and read results into the output beat.
                if (!out_valid_reg || m_ready) begin
                    out_next.bin_level = level_reg;
                    out_next.scope_hit = hit_reg;
                    if (item_reg.mode == MODE_PIXEL) begin
                        out_next.blue_first   = pix_first.blue;
                        out_next.green_first  = pix_first.green;
                        out_next.red_first    = pix_first.red;
                        out_next.blue_second  = pix_second.blue;
                        out_next.green_second = pix_second.green;
                        out_next.red_second   = pix_second.red;
                    end else begin
                        out_next.blue_first   = '0;
                        out_next.green_first  = '0;
                        out_next.red_first    = '0;
                        out_next.blue_second  = '0;
                        out_next.green_second = '0;
                        out_next.red_second   = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            peak_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            peak_reg      <= peak_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg  <= item_next;
        level_reg <= level_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
        if (state_reg == ST_RD) begin
            prod_b_reg <= prod_b_next;
            prod_g_reg <= prod_g_next;
            prod_r_reg <= prod_r_next;
        end
    end

    // Two pixel lanes share the chroma terms.
    ybh_lane u_lane_first (
        .luma   (item_reg.luma_first),
        .term_b (prod_b_reg),
        .term_g (prod_g_reg),
        .term_r (prod_r_reg),
        .pixel  (pix_first)
    );

    ybh_lane u_lane_second (
        .luma   (item_reg.luma_second),
        .term_b (prod_b_reg),
        .term_g (prod_g_reg),
        .term_r (prod_r_reg),
        .pixel  (pix_second)
    );

    ybh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    ybh_ram #(
        .WIDTH (SCOPE_COLS),
        .DEPTH (SCOPE_ROWS)
    ) u_scope_ram (
        .aclk  (aclk),
        .we    (scope_we),
        .waddr (scope_waddr),
        .wdata (scope_wdata),
        .raddr (scope_raddr),
        .rdata (scope_rdata)
    );

    ybh_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({hist_rdata, 8'h00}),
        .den     (peak_reg),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    // A new result beat only appears after the handoff state.
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the handoff state");

    // The divider finishes only while the sequencer waits for it.
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // A clearing pass leaves the peak at zero.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> (peak_reg == '0))
        else $error("peak not cleared by the clearing pass");

    // A result carries at most one of the read values.
    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.bin_level == 16'h0000 || !m_data.scope_hit))
        else $error("bin level and scope bit both set");
`endif

endmodule
`default_nettype wire
